>>> rtl/core/mpts_pkg.sv
// Package for the multi-policy task scheduler: constants, codes and beat structs.
// No dependencies; the scheduler and mpts_csr import it, mpts_ram does not.
package mpts_pkg;

   localparam int MaxTasksDefault = 16;
   localparam int TimeMaxDefault  = 1000;

   localparam logic [1:0] POL_FCFS = 2'd0;
   localparam logic [1:0] POL_SRT  = 2'd1;
   localparam logic [1:0] POL_PRIO = 2'd2;
   localparam logic [1:0] POL_RR   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_ARR  = 2'd1;
   localparam logic [1:0] ST_ZERO_CPU = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [2:0] PL_FREE    = 3'd0;
   localparam logic [2:0] PL_PENDING = 3'd1;
   localparam logic [2:0] PL_READY   = 3'd2;
   localparam logic [2:0] PL_RUNNING = 3'd3;
   localparam logic [2:0] PL_IO      = 3'd4;
   localparam logic [2:0] PL_DONE    = 3'd5;

   localparam logic [1:0] REG_POLICY  = 2'd0;
   localparam logic [1:0] REG_PREEMPT = 2'd1;
   localparam logic [1:0] REG_QUANTUM = 2'd2;

   localparam logic FUNC_LOAD = 1'b0;

   typedef struct packed {
      logic       func;
      logic [9:0] task_id;
      logic [7:0] task_priority;
      logic [9:0] arrival_tick;
      logic [7:0] cpu_burst;
      logic [7:0] io_burst;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] now_tick;
      logic [9:0]  running_id;
      logic        switched;
      logic        done_valid;
      logic [9:0]  done_id;
      logic [15:0] done_waiting;
      logic [15:0] done_turnaround;
      logic [15:0] done_response;
      logic        all_done;
   } rsp_type;

   // One task table entry as held in the slot memory.
   typedef struct packed {
      logic [9:0]  id;
      logic [7:0]  priority_v;
      logic [9:0]  arrival;
      logic [7:0]  cpu_left;
      logic [7:0]  io_left;
      logic [15:0] wait_count;
      logic [15:0] turn_count;
      logic [15:0] response;
      logic        responded;
   } slot_type;

   localparam int SlotWidth = $bits(slot_type);

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

>>> rtl/core/multi_policy_task_scheduler.sv
// Multi-policy task scheduler (FCFS, shortest remaining, priority, round robin).
// A load beat checks and writes one slot; a tick beat's result is set by sweeps over the
// slot memory, one entry read per cycle. One beat is handled at a time; a finished
// result waits in an output register while the next beat is processed, and the block stalls
// only when a second result is ready before the first is taken.
// Synchronous reset clears the state, counts and slot places, which empties the lists.
module multi_policy_task_scheduler #(
   parameter int MaxTasks = mpts_pkg::MaxTasksDefault,
   parameter int TimeMax  = mpts_pkg::TimeMaxDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mpts_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mpts_pkg::rsp_type    rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import mpts_pkg::*;

   localparam int AW = $clog2(MaxTasks);
   localparam int CW = $clog2(MaxTasks + 1);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_LOAD   = 10'b0000000010,
      S_ARRIVE = 10'b0000000100,
      S_PICK   = 10'b0000001000,
      S_SELECT = 10'b0000010000,
      S_AGE    = 10'b0000100000,
      S_IOCNT  = 10'b0001000000,
      S_RUN    = 10'b0010000000,
      S_RUNWB  = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;

   logic [1:0] policy;
   logic       preempt_enable;
   logic [7:0] quantum;

   mpts_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .policy, .preempt_enable, .quantum
   );

   // Slot memory
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   slot_type       mem_wdata, mem_rdata;

   mpts_ram #(.Width(SlotWidth), .Depth(MaxTasks)) u_slots (
      .clock, .wr_en(mem_we), .wr_addr(mem_waddr),
      .wr_data(mem_wdata), .rd_addr(mem_raddr), .rd_data(mem_rdata)
   );

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   rsp_type       wrk_ff, wrk_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    place_ff [MaxTasks];
   logic [2:0]    place_in [MaxTasks];
   logic [AW-1:0] rdy_ff [MaxTasks];
   logic [AW-1:0] rdy_in [MaxTasks];
   logic [AW-1:0] io_ff [MaxTasks];
   logic [AW-1:0] io_in [MaxTasks];
   logic [CW-1:0] rdy_cnt_ff, rdy_cnt_in, io_cnt_ff, io_cnt_in;
   logic [CW-1:0] loaded_ff, loaded_in, fin_ff, fin_in;
   logic          run_v_ff, run_v_in;
   logic [AW-1:0] run_s_ff, run_s_in;
   logic [7:0]    slice_ff, slice_in;
   logic [15:0]   tick_ff, tick_in;
   // sweep control
   logic [CW-1:0] idx_ff, idx_in;    // read index issued
   logic          pv_ff, pv_in;      // read data valid next cycle
   logic [CW-1:0] pidx_ff, pidx_in;  // index belonging to read data
   // best-candidate search
   logic [CW-1:0] bpos_ff, bpos_in;
   logic [8:0]    bkey_ff, bkey_in;
   logic [9:0]    barr_ff, barr_in;
   logic          prev_v_ff, prev_v_in;
   logic [AW-1:0] prev_s_ff, prev_s_in;
   logic [CW-1:0] io_wr_ff, io_wr_in;
   logic [AW-1:0] io_tmp [MaxTasks];
   slot_type      cur;
   logic [7:0]    key8;
   logic [AW-1:0] rslot;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cur       = mem_rdata;
   assign key8      = (policy == POL_SRT) ? cur.cpu_left : cur.priority_v;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      wrk_in       = wrk_ff;
      rsp_valid_in = rsp_valid_ff;
      place_in     = place_ff;
      rdy_in       = rdy_ff;
      io_in        = io_ff;
      rdy_cnt_in   = rdy_cnt_ff;
      io_cnt_in    = io_cnt_ff;
      loaded_in    = loaded_ff;
      fin_in       = fin_ff;
      run_v_in     = run_v_ff;
      run_s_in     = run_s_ff;
      slice_in     = slice_ff;
      tick_in      = tick_ff;
      idx_in       = idx_ff;
      pv_in        = 1'b0;
      pidx_in      = idx_ff;
      bpos_in      = bpos_ff;
      bkey_in      = bkey_ff;
      barr_in      = barr_ff;
      prev_v_in    = prev_v_ff;
      prev_s_in    = prev_s_ff;
      io_wr_in     = io_wr_ff;
      io_tmp       = io_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = cur;
      mem_raddr    = '0;
      rslot        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               wrk_in = '0;
               state_in = (req_data.func == FUNC_LOAD) ? S_LOAD : S_ARRIVE;
            end
         end
         S_LOAD: begin
            priority if ({22'd0, req_ff.arrival_tick} > TimeMax) begin
               wrk_in.status = ST_BAD_ARR;
            end else if (req_ff.cpu_burst == 8'd0) begin
               wrk_in.status = ST_ZERO_CPU;
            end else if ({{(32-CW){1'b0}}, loaded_ff} >= MaxTasks) begin
               wrk_in.status = ST_FULL;
            end else begin
               wrk_in.status = ST_OK;
               mem_we    = 1'b1;
               mem_waddr = loaded_ff[AW-1:0];
               mem_wdata = '{id: req_ff.task_id, priority_v: req_ff.task_priority,
                             arrival: req_ff.arrival_tick, cpu_left: req_ff.cpu_burst,
                             io_left: req_ff.io_burst, wait_count: 16'd0,
                             turn_count: 16'd0, response: 16'd0, responded: 1'b0};
               place_in[loaded_ff[AW-1:0]] = PL_PENDING;
               loaded_in = loaded_ff + 1'b1;
            end
            state_in = S_OUT;
         end
         S_ARRIVE: begin
            // Sweep slots in order; pending ones arriving now join the ready list.
            mem_raddr = idx_ff[AW-1:0];
            if (idx_ff < loaded_ff) begin
               idx_in = idx_ff + 1'b1;
               pv_in  = 1'b1;
            end
            if (pv_ff && place_ff[pidx_ff[AW-1:0]] == PL_PENDING &&
                {6'd0, cur.arrival} == tick_ff) begin
               rdy_in[rdy_cnt_ff[AW-1:0]] = pidx_ff[AW-1:0];
               rdy_cnt_in = rdy_cnt_ff + 1'b1;
               place_in[pidx_ff[AW-1:0]] = PL_READY;
            end
            if (idx_ff >= loaded_ff && !pv_ff) begin
               idx_in    = '0;
               bpos_in   = '0;
               prev_v_in = run_v_ff;
               prev_s_in = run_s_ff;
               state_in  = S_PICK;
            end
         end
         S_PICK: begin
            // Search ready list for best key; last read fetches the running slot.
            if (idx_ff < rdy_cnt_ff) begin
               mem_raddr = rdy_ff[idx_ff[AW-1:0]];
               idx_in = idx_ff + 1'b1;
               pv_in  = 1'b1;
            end else begin
               mem_raddr = run_s_ff;
            end
            if (pv_ff) begin
               if (pidx_ff == '0 || {1'b0, key8} < bkey_ff ||
                   ({1'b0, key8} == bkey_ff && cur.arrival < barr_ff)) begin
                  bpos_in = pidx_ff;
                  bkey_in = {1'b0, key8};
                  barr_in = cur.arrival;
               end
            end
            if (idx_ff >= rdy_cnt_ff && !pv_ff) begin
               state_in = S_SELECT;
            end
         end
         S_SELECT: begin
            if (rdy_cnt_ff != '0) begin
               logic take;
               logic requeue;
               logic [CW-1:0] pos;
               take = 1'b0; requeue = 1'b0; pos = '0;
               if (policy == POL_FCFS) begin
                  take = !run_v_ff;
               end else if (policy == POL_RR) begin
                  if (!run_v_ff) take = 1'b1;
                  else if (slice_ff >= quantum) begin
                     take = 1'b1; requeue = 1'b1;
                  end
               end else begin
                  pos = bpos_ff;
                  if (!run_v_ff) take = 1'b1;
                  else if (preempt_enable &&
                           ({1'b0, key8} > bkey_ff ||
                            ({1'b0, key8} == bkey_ff && cur.arrival > barr_ff))) begin
                     take = 1'b1; requeue = 1'b1;
                  end
               end
               if (take) begin
                  logic [AW-1:0] tmp [MaxTasks];
                  logic [CW-1:0] cnt;
                  tmp = rdy_ff;
                  cnt = rdy_cnt_ff;
                  if (requeue) begin
                     tmp[cnt[AW-1:0]] = run_s_ff;
                     place_in[run_s_ff] = PL_READY;
                     cnt = cnt + 1'b1;
                  end
                  run_s_in = tmp[pos[AW-1:0]];
                  place_in[tmp[pos[AW-1:0]]] = PL_RUNNING;
                  for (int i = 0; i < MaxTasks - 1; i++) begin
                     if (i >= int'(pos)) tmp[i] = tmp[i + 1];
                  end
                  rdy_in = tmp;
                  rdy_cnt_in = cnt - 1'b1;
                  run_v_in = 1'b1;
               end
            end
            idx_in   = '0;
            state_in = S_AGE;
         end
         S_AGE: begin
            // Read-modify-write each ready slot; one read per cycle.
            if (idx_ff < rdy_cnt_ff) begin
               mem_raddr = rdy_ff[idx_ff[AW-1:0]];
               idx_in = idx_ff + 1'b1;
               pv_in  = 1'b1;
            end
            if (pv_ff) begin
               rslot = rdy_ff[pidx_ff[AW-1:0]];
               mem_we    = 1'b1;
               mem_waddr = rslot;
               mem_wdata.wait_count = sat_inc16(cur.wait_count);
               mem_wdata.turn_count = sat_inc16(cur.turn_count);
            end
            if (idx_ff >= rdy_cnt_ff && !pv_ff) begin
               idx_in   = '0;
               io_wr_in = '0;
               state_in = S_IOCNT;
            end
         end
         S_IOCNT: begin
            // Count down I/O waits; finished ones rejoin the ready list in order.
            if (idx_ff < io_cnt_ff) begin
               mem_raddr = io_ff[idx_ff[AW-1:0]];
               idx_in = idx_ff + 1'b1;
               pv_in  = 1'b1;
            end
            if (pv_ff) begin
               rslot = io_ff[pidx_ff[AW-1:0]];
               mem_we    = 1'b1;
               mem_waddr = rslot;
               mem_wdata.turn_count = sat_inc16(cur.turn_count);
               if (cur.io_left > 8'd1) begin
                  mem_wdata.io_left = cur.io_left - 8'd1;
                  io_tmp[io_wr_ff[AW-1:0]] = rslot;
                  io_in = io_tmp;
                  io_wr_in = io_wr_ff + 1'b1;
               end else begin
                  mem_wdata.io_left = 8'd0;
                  rdy_in[rdy_cnt_ff[AW-1:0]] = rslot;
                  rdy_cnt_in = rdy_cnt_ff + 1'b1;
                  place_in[rslot] = PL_READY;
               end
            end
            if (idx_ff >= io_cnt_ff && !pv_ff) begin
               io_cnt_in = io_wr_ff;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            mem_raddr = run_s_ff;
            state_in  = S_RUNWB;
         end
         S_RUNWB: begin
            logic sw;
            logic [7:0] cl;
            sw = (run_v_ff != prev_v_ff) || (run_v_ff && run_s_ff != prev_s_ff);
            cl = 8'd0;
            wrk_in.status   = ST_OK;
            wrk_in.now_tick = tick_ff;
            wrk_in.switched = sw;
            if (run_v_ff) begin
               slot_type w;
               w = cur;
               if (sw) begin
                  slice_in = 8'd0;
                  if (!cur.responded) begin
                     w.response  = tick_ff - {6'd0, cur.arrival};
                     w.responded = 1'b1;
                  end
               end
               cl = (w.cpu_left != 8'd0) ? w.cpu_left - 8'd1 : 8'd0;
               w.cpu_left   = cl;
               w.turn_count = sat_inc16(w.turn_count);
               if (sw) slice_in = 8'd1;
               else if (slice_ff != 8'hFF) slice_in = slice_ff + 8'd1;
               wrk_in.running_id = w.id;
               mem_we    = 1'b1;
               mem_waddr = run_s_ff;
               mem_wdata = w;
               if (cl == 8'd0) begin
                  place_in[run_s_ff] = PL_DONE;
                  fin_in   = fin_ff + 1'b1;
                  run_v_in = 1'b0;
                  wrk_in.done_valid      = 1'b1;
                  wrk_in.done_id         = w.id;
                  wrk_in.done_waiting    = w.wait_count;
                  wrk_in.done_turnaround = w.turn_count;
                  wrk_in.done_response   = w.response;
               end else if (w.io_left != 8'd0) begin
                  io_in[io_cnt_ff[AW-1:0]] = run_s_ff;
                  io_cnt_in = io_cnt_ff + 1'b1;
                  place_in[run_s_ff] = PL_IO;
                  run_v_in = 1'b0;
               end
            end
            tick_in  = sat_inc16(tick_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_in = wrk_ff;
               rsp_in.all_done = (fin_in == loaded_in);
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rdy_cnt_ff   <= '0;
         io_cnt_ff    <= '0;
         loaded_ff    <= '0;
         fin_ff       <= '0;
         run_v_ff     <= 1'b0;
         run_s_ff     <= '0;
         slice_ff     <= '0;
         tick_ff      <= '0;
         idx_ff       <= '0;
         pv_ff        <= 1'b0;
         for (int i = 0; i < MaxTasks; i++) place_ff[i] <= PL_FREE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rdy_cnt_ff   <= rdy_cnt_in;
         io_cnt_ff    <= io_cnt_in;
         loaded_ff    <= loaded_in;
         fin_ff       <= fin_in;
         run_v_ff     <= run_v_in;
         run_s_ff     <= run_s_in;
         slice_ff     <= slice_in;
         tick_ff      <= tick_in;
         idx_ff       <= idx_in;
         pv_ff        <= pv_in;
         place_ff     <= place_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      wrk_ff     <= wrk_in;
      rdy_ff     <= rdy_in;
      io_ff      <= io_in;
      pidx_ff    <= pidx_in;
      bpos_ff    <= bpos_in;
      bkey_ff    <= bkey_in;
      barr_ff    <= barr_in;
      prev_v_ff  <= prev_v_in;
      prev_s_ff  <= prev_s_in;
      io_wr_ff   <= io_wr_in;
   end

   a_fin_le_loaded: assert property (@(posedge clock) disable iff (reset)
      fin_ff <= loaded_ff) else $error("finished count exceeds loaded count");
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE)) else $error("ready outside idle");
   a_lists_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IOCNT) |->
      (({1'b0, rdy_cnt_ff} + {1'b0, io_cnt_ff}) <= {1'b0, loaded_ff}))
      else $error("ready and I/O lists exceed loaded tasks");
endmodule

>>> rtl/core/mpts_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
module mpts_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/mpts_csr.sv
// APB-style configuration registers: policy, preemption enable and quantum.
// Depends on mpts_pkg.
module mpts_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [1:0]  policy,
   output logic        preempt_enable,
   output logic [7:0]  quantum
);
   import mpts_pkg::*;

   logic [1:0] policy_ff;
   logic       preempt_ff;
   logic [7:0] quantum_ff;
   logic       wr;
   logic [1:0] idx;

   assign wr  = psel && penable && pwrite;
   assign idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= POL_FCFS;
         preempt_ff <= 1'b0;
         quantum_ff <= 8'd4;
      end else if (wr) begin
         unique case (idx)
            REG_POLICY:  policy_ff  <= pwdata[1:0];
            REG_PREEMPT: preempt_ff <= pwdata[0];
            REG_QUANTUM: quantum_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_POLICY:  prdata = {30'd0, policy_ff};
         REG_PREEMPT: prdata = {31'd0, preempt_ff};
         REG_QUANTUM: prdata = {24'd0, quantum_ff};
         default:     prdata = '0;
      endcase
   end

   assign pready         = 1'b1;
   assign policy         = policy_ff;
   assign preempt_enable = preempt_ff;
   assign quantum        = quantum_ff;
endmodule
